// ===== hdl/swvr_pkg.sv =====
// Shared types and constants for the stack with value removal.
// No dependencies; used by every module of the block.
package swvr_pkg;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;
    localparam int OUT_BITS    = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Per-cycle commands broadcast to every cell of the row.
    typedef struct packed {
        logic push;    // shift toward the bottom, load value into the top cell
        logic pop;     // shift toward the top
        logic remove;  // shift toward the top from the first match on
    } cell_ctrl_t;

endpackage

// ===== hdl/stack_with_value_removal_core.sv =====
// Top level of the bounded LIFO stack with delete-by-value.
// Depends on swvr_pkg and swvr_row (which instantiates swvr_cell).
//
// Bounded LIFO stack of DEPTH words. Each request transfer carries an op
// (push, pop, remove topmost matching value) and a value; each one yields
// exactly one result transfer with the popped value (zero unless a pop
// succeeds), a status (ok, full, empty, not found) and the entry count after
// the operation. Words are stored and compared in the low WORD_BITS bits of
// s_value; m_read_value carries the stored word zero-extended. Op code three
// leaves the stack unchanged and reports ok. The stack lives in a row of
// DEPTH cells with the top in cell 0: push shifts every cell one place down,
// pop shifts one place up, and remove shifts up every cell from the first
// match on, so the match search and the shift finish in the same cycle as
// the request. Throughput is one request per clock unless results stall; the
// result appears in the output register in the cycle after the transfer.
// The cycle time is set by the match ripple through the DEPTH cells of the
// row. Stored words have no reset; only occupied cells are ever read or compared.
module stack_with_value_removal_core #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [swvr_pkg::OP_BITS-1:0]         s_op,
    input  logic signed [31:0]                   s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [swvr_pkg::OUT_BITS-1:0] m_read_value,
    output logic [swvr_pkg::STATUS_BITS-1:0]     m_status,
    output logic [swvr_pkg::COUNT_BITS-1:0]      m_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                      accept;
    logic [WORD_BITS-1:0]      word;
    logic [WORD_BITS-1:0]      top_data;
    logic                      found;
    logic                      full;
    logic                      empty;
    swvr_pkg::cell_ctrl_t      ctrl;
    swvr_pkg::status_t         status;
    logic [WORD_BITS-1:0]      read_word;

    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          fill_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [WORD_BITS-1:0]      read_reg;
    swvr_pkg::status_t         status_reg;
    logic [CNT_W-1:0]          count_reg;

    // Take a new request whenever the output register is empty or drains now.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Fit the request value to the stored word width.
    if (WORD_BITS <= 32) begin : g_in_narrow
        assign word = s_value[WORD_BITS-1:0];
    end else begin : g_in_wide
        assign word = {{(WORD_BITS-32){1'b0}}, s_value};
    end

    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign empty = (fill_reg == '0);

    // Decode the request; drive the cell row only for transfers that change state.
    always_comb begin
        ctrl      = '0;
        status    = swvr_pkg::ST_OK;
        read_word = '0;
        fill_next = fill_reg;
        case (s_op)
            swvr_pkg::OP_PUSH: begin
                if (full) begin
                    status = swvr_pkg::ST_FULL;
                end else begin
                    ctrl.push = accept;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            swvr_pkg::OP_POP: begin
                if (empty) begin
                    status = swvr_pkg::ST_EMPTY;
                end else begin
                    ctrl.pop  = accept;
                    read_word = top_data;
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            swvr_pkg::OP_REMOVE: begin
                if (!found) begin
                    status = swvr_pkg::ST_NOT_FOUND;
                end else begin
                    ctrl.remove = accept;
                    fill_next   = fill_reg - CNT_W'(1);
                end
            end
            default: begin
                // Unused op: hold the stack, report ok.
                status = swvr_pkg::ST_OK;
            end
        endcase
    end

    swvr_row #(
        .DEPTH    (DEPTH),
        .WORD_BITS(WORD_BITS),
        .CNT_W    (CNT_W)
    ) u_row (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .value   (word),
        .count   (fill_reg),
        .top_data(top_data),
        .found   (found)
    );

    // Output valid: set on a request transfer, drop once the result is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                fill_reg <= fill_next;
            end
        end
    end

    // Result payload; advance only on a request transfer.
    always_ff @(posedge aclk) begin
        if (accept) begin
            read_reg   <= read_word;
            status_reg <= status;
            count_reg  <= fill_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;

    if (WORD_BITS >= swvr_pkg::OUT_BITS) begin : g_out_wide
        assign m_read_value = read_reg[swvr_pkg::OUT_BITS-1:0];
    end else begin : g_out_narrow
        assign m_read_value = {{(swvr_pkg::OUT_BITS-WORD_BITS){1'b0}}, read_reg};
    end

    if (CNT_W >= swvr_pkg::COUNT_BITS) begin : g_cnt_wide
        assign m_count = count_reg[swvr_pkg::COUNT_BITS-1:0];
    end else begin : g_cnt_narrow
        assign m_count = {{(swvr_pkg::COUNT_BITS-CNT_W){1'b0}}, count_reg};
    end

endmodule

// ===== hdl/swvr_cell.sv =====
// One stack cell: holds a word, compares it to the request value and shifts.
// Depends on swvr_pkg.
module swvr_cell #(
    parameter int WORD_BITS = 32,
    parameter int CNT_W     = 5,
    parameter int IDX       = 0
) (
    input  logic                  aclk,
    input  swvr_pkg::cell_ctrl_t  ctrl,
    input  logic [WORD_BITS-1:0]  value,
    input  logic [CNT_W-1:0]      count,
    input  logic [WORD_BITS-1:0]  prev_data,
    input  logic [WORD_BITS-1:0]  next_data,
    input  logic                  found_in,
    output logic [WORD_BITS-1:0]  data,
    output logic                  found_out
);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 occupied;

    assign occupied  = (count > CNT_W'(IDX));
    // Found at this cell or at one nearer the top.
    assign found_out = found_in | (occupied && (data_reg == value));
    assign data      = data_reg;

    always_comb begin
        data_next = data_reg;
        if (ctrl.push) begin
            data_next = prev_data;
        end else if (ctrl.pop || (ctrl.remove && found_out)) begin
            data_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

// ===== hdl/swvr_row.sv =====
// Row of DEPTH stack cells, top of stack in cell 0.
// Depends on swvr_pkg and swvr_cell.
module swvr_row #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int CNT_W     = 5
) (
    input  logic                  aclk,
    input  swvr_pkg::cell_ctrl_t  ctrl,
    input  logic [WORD_BITS-1:0]  value,
    input  logic [CNT_W-1:0]      count,
    output logic [WORD_BITS-1:0]  top_data,
    output logic                  found
);

    logic [WORD_BITS-1:0] cell_data [DEPTH];
    logic [DEPTH:0]       found_chain;

    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_BITS-1:0] prev_d;
        logic [WORD_BITS-1:0] next_d;

        if (i == 0) begin : g_first
            assign prev_d = value;
        end else begin : g_mid
            assign prev_d = cell_data[i-1];
        end

        // The bottom cell has nothing below it; hold.
        if (i == DEPTH - 1) begin : g_last
            assign next_d = cell_data[i];
        end else begin : g_inner
            assign next_d = cell_data[i+1];
        end

        swvr_cell #(
            .WORD_BITS(WORD_BITS),
            .CNT_W    (CNT_W),
            .IDX      (i)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .value    (value),
            .count    (count),
            .prev_data(prev_d),
            .next_data(next_d),
            .found_in (found_chain[i]),
            .data     (cell_data[i]),
            .found_out(found_chain[i+1])
        );
    end

    assign top_data = cell_data[0];
    assign found    = found_chain[DEPTH];

endmodule

// ===== hdl/swvr_checker.sv =====
// Port-level checks for stack_with_value_removal_core, attached by bind.
// Depends on swvr_pkg.
module swvr_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [swvr_pkg::OUT_BITS-1:0] m_read_value,
    input logic [swvr_pkg::STATUS_BITS-1:0]     m_status,
    input logic [swvr_pkg::COUNT_BITS-1:0]      m_count
);

    // An empty pop reports zero entries and no data.
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == swvr_pkg::ST_EMPTY) |-> (m_count == '0 && m_read_value == '0))
        else $error("empty status with nonzero count or data");

    // Only a successful pop carries data; failed pushes and removes return zero.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == swvr_pkg::ST_FULL || m_status == swvr_pkg::ST_NOT_FOUND))
        |-> (m_read_value == '0))
        else $error("failed operation returned data");

    // A request transfer produces a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("request transfer without a result");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_value) && $stable(m_status)
        && $stable(m_count)))
        else $error("stalled result changed");

endmodule

bind stack_with_value_removal_core swvr_checker u_swvr_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for stack_with_value_removal_core: push, pop and remove-by-value.
// Depends on swvr_pkg and the RTL under hdl/; a scoreboard class predicts every result.
module tb_top;

    localparam int STACK_DEPTH   = 16;
    localparam int WORD_W        = 32;
    localparam int RANDOM_ITEMS  = 950;
    localparam int QUIET_ITEMS   = 150;   // last stretch of the run runs with no idling
    localparam int LONG_HOLD     = 80;    // cycles the receiver holds off to back up the block
    localparam int BURST_START   = 300;
    localparam int BURST_LEN     = 40;
    localparam int PAUSE_AT      = 600;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int TAIL_CYCLES   = 8;

    // Op code three has no name in the package; the block must ignore it.
    localparam logic [swvr_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

    // Op mixes for the random segments.
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    typedef struct {
        logic [swvr_pkg::OUT_BITS-1:0]    read_value;
        logic [swvr_pkg::STATUS_BITS-1:0] status;
        logic [swvr_pkg::COUNT_BITS-1:0]  count;
    } stack_result_t;

    // Shadow copy of the stack; entry 0 is the bottom, entry fill-1 the top.
    class stack_scoreboard;
        logic [WORD_W-1:0] shadow_words [STACK_DEPTH];
        int                shadow_fill;
        stack_result_t     pending_results [$];
        int                failures;

        function new();
            shadow_fill = 0;
            failures    = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted request to the shadow stack and queue its result.
        function void note_request(logic [swvr_pkg::OP_BITS-1:0] op, logic [31:0] value);
            stack_result_t     r;
            logic [WORD_W-1:0] w;
            int                hit;
            w            = value[WORD_W-1:0];
            r.read_value = '0;
            r.status     = swvr_pkg::ST_OK;
            case (op)
                swvr_pkg::OP_PUSH: begin
                    if (shadow_fill >= STACK_DEPTH) begin
                        r.status = swvr_pkg::ST_FULL;
                    end else begin
                        shadow_words[shadow_fill] = w;
                        shadow_fill++;
                    end
                end
                swvr_pkg::OP_POP: begin
                    if (shadow_fill == 0) begin
                        r.status = swvr_pkg::ST_EMPTY;
                    end else begin
                        shadow_fill--;
                        r.read_value[WORD_W-1:0] = shadow_words[shadow_fill];
                    end
                end
                swvr_pkg::OP_REMOVE: begin
                    hit = -1;
                    for (int i = shadow_fill - 1; i >= 0; i--) begin
                        if (hit < 0 && shadow_words[i] == w) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = swvr_pkg::ST_NOT_FOUND;
                    end else begin
                        for (int k = hit; k + 1 < shadow_fill; k++)
                            shadow_words[k] = shadow_words[k + 1];
                        shadow_fill--;
                    end
                end
                default: ;
            endcase
            r.count = shadow_fill[swvr_pkg::COUNT_BITS-1:0];
            pending_results.push_back(r);
        endfunction

        // Compare one result transfer against the oldest prediction.
        function void check_result(logic [swvr_pkg::OUT_BITS-1:0] rv,
                                   logic [swvr_pkg::STATUS_BITS-1:0] st,
                                   logic [swvr_pkg::COUNT_BITS-1:0] cnt);
            stack_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: read_value %h status %0d count %0d",
                         $time, rv, st, cnt);
                failures++;
                return;
            end
            e = pending_results.pop_front();
            if (rv !== e.read_value) begin
                $display("%0t: read_value expected %h actual %h", $time, e.read_value, rv);
                failures++;
            end
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                failures++;
            end
            if (cnt !== e.count) begin
                $display("%0t: count expected %0d actual %0d", $time, e.count, cnt);
                failures++;
            end
        endfunction
    endclass

    logic                                 aclk    = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [swvr_pkg::OP_BITS-1:0]         s_op    = '0;
    logic signed [31:0]                   s_value = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic signed [swvr_pkg::OUT_BITS-1:0] m_read_value;
    logic [swvr_pkg::STATUS_BITS-1:0]     m_status;
    logic [swvr_pkg::COUNT_BITS-1:0]      m_count;

    // Handshake between the stimulus and the receiver process.
    bit quiet     = 1'b0;   // no idling on either side
    bit long_hold = 1'b0;   // ask the receiver for one long hold-off

    stack_scoreboard stack_sb = new();

    stack_with_value_removal_core #(
        .DEPTH     (STACK_DEPTH),
        .WORD_BITS (WORD_W)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_count      (m_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Sample both channels at the edge. Note the request first so that a result
    // accepted at the same edge always finds its prediction already queued.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) stack_sb.note_request(s_op, s_value);
        if (aresetn && m_valid && m_ready) stack_sb.check_result(m_read_value, m_status, m_count);
    end

    // Offer one request after an optional idle gap. Valid stays high after the
    // transfer so that back-to-back requests never lower and raise it in one step.
    task automatic send_request(input logic [swvr_pkg::OP_BITS-1:0] op,
                                input logic [31:0] value, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and hold until every predicted result has been transferred.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (stack_sb.pending() != 0);
    endtask

    // Favor a small pool so removes hit and duplicates occur; the rest is random.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return 32'h1234_5678;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [swvr_pkg::OP_BITS-1:0] pick_op(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return OP_UNUSED;
        case (mode)
            MODE_FILL:  return (r < 70) ? swvr_pkg::OP_PUSH :
                               (r < 85) ? swvr_pkg::OP_POP : swvr_pkg::OP_REMOVE;
            MODE_DRAIN: return (r < 18) ? swvr_pkg::OP_PUSH :
                               (r < 65) ? swvr_pkg::OP_POP : swvr_pkg::OP_REMOVE;
            default:    return (r < 45) ? swvr_pkg::OP_PUSH :
                               (r < 75) ? swvr_pkg::OP_POP : swvr_pkg::OP_REMOVE;
        endcase
    endfunction

    // Receiver: random ready stretches and stall bursts, one long hold-off on
    // request, and no stalls once the run goes quiet.
    initial begin : result_sink
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Abort when neither channel has moved a transfer for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_MAX) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int mode;
        int gap;
        bit burst;
        mode = MODE_MIX;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty stack: pop reports empty, remove finds nothing, op three is ignored.
        send_request(swvr_pkg::OP_POP,    32'h0000_0000, 0);
        send_request(swvr_pkg::OP_REMOVE, 32'h0000_0000, 0);
        send_request(OP_UNUSED,           32'hFFFF_FFFF, 0);
        // Field extremes and a duplicated value.
        send_request(swvr_pkg::OP_PUSH,   32'h8000_0000, 0);
        send_request(swvr_pkg::OP_PUSH,   32'h7FFF_FFFF, 2);
        send_request(swvr_pkg::OP_PUSH,   32'h0000_0000, 0);
        send_request(swvr_pkg::OP_PUSH,   32'hFFFF_FFFF, 0);
        send_request(swvr_pkg::OP_PUSH,   32'h0000_0005, 0);
        send_request(swvr_pkg::OP_PUSH,   32'h5555_5555, 0);
        send_request(swvr_pkg::OP_PUSH,   32'h0000_0005, 0);
        // Only the topmost of the two fives goes; then a miss on a full search.
        send_request(swvr_pkg::OP_REMOVE, 32'h0000_0005, 0);
        send_request(swvr_pkg::OP_REMOVE, 32'h0000_0309, 0);
        // Remove the bottom entry: everything above shifts down.
        send_request(swvr_pkg::OP_REMOVE, 32'h8000_0000, 1);
        send_request(swvr_pkg::OP_POP,    32'hAAAA_AAAA, 0);
        // Fill to the brim, then push into a full stack and exercise it there.
        repeat (STACK_DEPTH - 4) send_request(swvr_pkg::OP_PUSH, $urandom, 0);
        send_request(swvr_pkg::OP_PUSH,   32'h0BAD_F00D, 0);
        send_request(OP_UNUSED,           32'h0000_0000, 0);
        send_request(swvr_pkg::OP_REMOVE, 32'h0000_0000, 0);
        send_request(swvr_pkg::OP_PUSH,   32'hFFFF_FFFF, 0);
        send_request(swvr_pkg::OP_POP,    32'h0000_0000, 0);
        wait_drained();

        // Random segments: each one leans toward filling, draining or a mix,
        // so both the full and the empty boundary are reached many times.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) mode = $urandom_range(MODE_FILL, MODE_MIX);
            if (n == BURST_START) long_hold = 1'b1;
            if (n == PAUSE_AT) wait_drained();
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            burst = (n >= BURST_START && n < BURST_START + BURST_LEN);
            gap = 0;
            if (!quiet && !burst && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 15);
            send_request(pick_op(mode), pick_value(), gap);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (stack_sb.failures == 0 && stack_sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== stack_with_value_removal_core.f =====
hdl/swvr_pkg.sv
hdl/swvr_cell.sv
hdl/swvr_row.sv
hdl/stack_with_value_removal_core.sv
hdl/swvr_checker.sv
sim/tb_top.sv
